### sv/topg_pkg.sv
package topg_pkg;

    localparam int TILE_ROWS = 4;
    localparam int TILE_COLS = 4;
    localparam int ACC_BITS_DEF = 48;

    localparam int IN_W = 16;
    localparam int PROD_W = 2 * IN_W;
    localparam int OUT_W = 32;
    localparam int ROW_W = $clog2(TILE_ROWS);

    localparam int SCL_W = 16;
    localparam int OFS_W = 32;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'b1;

    localparam logic signed [SCL_W-1:0] SCALE_RESET = 16'sd256;
    localparam logic signed [OFS_W-1:0] OFFSET_RESET = 32'sd0;

    // Accumulators are clamped to this many bits before scaling; anything
    // outside still saturates the output for every nonzero scale.
    localparam int CLAMP_BITS = 41;
    localparam int LO_BITS = 24;
    localparam int HI_BITS = CLAMP_BITS - LO_BITS;
    localparam int FRAC_SHIFT = 8;

    localparam int QUEUE_DEPTH = 4;

    typedef logic signed [IN_W-1:0] lane_t;

    typedef enum logic [1:0] {
        OP_ADD  = 2'b01,
        OP_LOAD = 2'b10
    } step_op_t;

    typedef struct packed {
        lane_t [TILE_ROWS-1:0] a;
        lane_t [TILE_COLS-1:0] b;
        step_op_t op;
        logic emit;
    } step_cmd_t;

endpackage

### sv/tile_outer_product_gemm.sv
// The block accumulates a 4x4 tile of D = alpha*A*B + gamma from outer products.
// Each input word carries one k-step: four A elements (one per tile row) and
// four B elements (one per tile column), all Q8.8, plus first_step to clear the
// accumulators before the add and last_step to emit the tile after it.
// Both channels use valid/ready; a word moves when both are high.
// The input side takes one word per cycle while s_ready is high. Its words pass
// through a register, a four-word queue and a product stage before the 16
// saturating accumulators. On a last step the tile is copied into an emit
// buffer, so accumulation of the next tile continues while rows drain. The rows
// follow one per cycle unless the receiver stalls, from row 0, final_row marking
// row 3. The emit buffer holds one tile, so a further last step waits until the
// previous tile has issued its four rows. When the receiver stalls, the scaling
// pipeline and output register hold and back-pressure reaches the input once the
// queue fills. Reset clears the accumulators and all valid state, and loads
// alpha = 1.0 and gamma = 0. The user must write registers through cfg_wr_en
// only while the block idles; the block itself does not enforce this.
module tile_outer_product_gemm #(
    parameter int ACC_BITS = topg_pkg::ACC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [topg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [topg_pkg::CFG_W-1:0]            cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  topg_pkg::lane_t                       s_a_lane0,
    input  topg_pkg::lane_t                       s_a_lane1,
    input  topg_pkg::lane_t                       s_a_lane2,
    input  topg_pkg::lane_t                       s_a_lane3,
    input  topg_pkg::lane_t                       s_b_lane0,
    input  topg_pkg::lane_t                       s_b_lane1,
    input  topg_pkg::lane_t                       s_b_lane2,
    input  topg_pkg::lane_t                       s_b_lane3,
    input  logic                                  s_first_step,
    input  logic                                  s_last_step,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [topg_pkg::OUT_W-1:0]     m_d_col0,
    output logic signed [topg_pkg::OUT_W-1:0]     m_d_col1,
    output logic signed [topg_pkg::OUT_W-1:0]     m_d_col2,
    output logic signed [topg_pkg::OUT_W-1:0]     m_d_col3,
    output logic [topg_pkg::ROW_W-1:0]            m_row_index,
    output logic                                  m_final_row
);
    import topg_pkg::*;

    logic signed [SCL_W-1:0] scale_reg;
    logic signed [OFS_W-1:0] offset_reg;

    logic                push_valid;
    logic                push_ready;
    step_cmd_t           push_cmd;
    logic                pop_valid;
    logic                pop_ready;
    step_cmd_t           pop_cmd;
    logic                tile_load;
    logic                tile_ready;
    logic [ACC_BITS-1:0] tile_acc [TILE_ROWS][TILE_COLS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
            offset_reg <= OFFSET_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCALE: scale_reg <= cfg_wr_data[SCL_W-1:0];
                REG_OFFSET: offset_reg <= cfg_wr_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    topg_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_a_lane0    (s_a_lane0),
        .s_a_lane1    (s_a_lane1),
        .s_a_lane2    (s_a_lane2),
        .s_a_lane3    (s_a_lane3),
        .s_b_lane0    (s_b_lane0),
        .s_b_lane1    (s_b_lane1),
        .s_b_lane2    (s_b_lane2),
        .s_b_lane3    (s_b_lane3),
        .s_first_step (s_first_step),
        .s_last_step  (s_last_step),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    topg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    topg_mac #(
        .ACC_BITS (ACC_BITS)
    ) u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .tile_load  (tile_load),
        .tile_ready (tile_ready),
        .tile_acc   (tile_acc)
    );

    topg_emit #(
        .ACC_BITS (ACC_BITS)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tile_load   (tile_load),
        .tile_ready  (tile_ready),
        .tile_acc    (tile_acc),
        .scale       (scale_reg),
        .offset      (offset_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_d_col0    (m_d_col0),
        .m_d_col1    (m_d_col1),
        .m_d_col2    (m_d_col2),
        .m_d_col3    (m_d_col3),
        .m_row_index (m_row_index),
        .m_final_row (m_final_row)
    );

endmodule

### sv/topg_front.sv
module topg_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  topg_pkg::lane_t     s_a_lane0,
    input  topg_pkg::lane_t     s_a_lane1,
    input  topg_pkg::lane_t     s_a_lane2,
    input  topg_pkg::lane_t     s_a_lane3,
    input  topg_pkg::lane_t     s_b_lane0,
    input  topg_pkg::lane_t     s_b_lane1,
    input  topg_pkg::lane_t     s_b_lane2,
    input  topg_pkg::lane_t     s_b_lane3,
    input  logic                s_first_step,
    input  logic                s_last_step,
    output logic                push_valid,
    input  logic                push_ready,
    output topg_pkg::step_cmd_t push_cmd
);
    import topg_pkg::*;

    logic      vld_reg;
    step_cmd_t cmd_reg;
    step_cmd_t cmd_next;

    always_comb begin
        cmd_next.a[0] = s_a_lane0;
        cmd_next.a[1] = s_a_lane1;
        cmd_next.a[2] = s_a_lane2;
        cmd_next.a[3] = s_a_lane3;
        cmd_next.b[0] = s_b_lane0;
        cmd_next.b[1] = s_b_lane1;
        cmd_next.b[2] = s_b_lane2;
        cmd_next.b[3] = s_b_lane3;
        cmd_next.op = s_first_step ? OP_LOAD : OP_ADD;
        cmd_next.emit = s_last_step;
    end

    assign s_ready = !vld_reg || push_ready;
    assign push_valid = vld_reg;
    assign push_cmd = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

### sv/topg_queue.sv
module topg_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  topg_pkg::step_cmd_t push_cmd,
    output logic                pop_valid,
    input  logic                pop_ready,
    output topg_pkg::step_cmd_t pop_cmd
);
    import topg_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    step_cmd_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_cmd = slot_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### sv/topg_mac.sv
module topg_mac #(
    parameter int ACC_BITS = topg_pkg::ACC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  topg_pkg::step_cmd_t pop_cmd,
    output logic                tile_load,
    input  logic                tile_ready,
    output logic [ACC_BITS-1:0] tile_acc [topg_pkg::TILE_ROWS][topg_pkg::TILE_COLS]
);
    import topg_pkg::*;

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    logic                       p_valid_reg;
    logic signed [PROD_W-1:0]   p_prod_reg [TILE_ROWS][TILE_COLS];
    step_op_t                   p_op_reg;
    logic                       p_emit_reg;
    logic signed [ACC_BITS-1:0] acc_reg [TILE_ROWS][TILE_COLS];
    logic signed [ACC_BITS-1:0] acc_next [TILE_ROWS][TILE_COLS];
    logic                       a_fire;

    assign a_fire = p_valid_reg && (!p_emit_reg || tile_ready);
    assign pop_ready = !p_valid_reg || a_fire;
    assign tile_load = a_fire && p_emit_reg;

    always_comb begin
        logic signed [ACC_BITS-1:0] base;
        logic signed [ACC_BITS:0]   sum;
        for (int r = 0; r < TILE_ROWS; r++) begin
            for (int c = 0; c < TILE_COLS; c++) begin
                unique case (p_op_reg)
                    OP_LOAD: base = '0;
                    default: base = acc_reg[r][c];
                endcase
                sum = {base[ACC_BITS-1], base}
                    + {{(ACC_BITS+1-PROD_W){p_prod_reg[r][c][PROD_W-1]}}, p_prod_reg[r][c]};
                if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
                    acc_next[r][c] = sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
                end else begin
                    acc_next[r][c] = sum[ACC_BITS-1:0];
                end
                tile_acc[r][c] = acc_next[r][c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (pop_ready) begin
            p_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            p_op_reg <= pop_cmd.op;
            p_emit_reg <= pop_cmd.emit;
            for (int r = 0; r < TILE_ROWS; r++) begin
                for (int c = 0; c < TILE_COLS; c++) begin
                    p_prod_reg[r][c] <= $signed(pop_cmd.a[r]) * $signed(pop_cmd.b[c]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < TILE_ROWS; r++) begin
                for (int c = 0; c < TILE_COLS; c++) begin
                    acc_reg[r][c] <= '0;
                end
            end
        end else if (a_fire) begin
            acc_reg <= acc_next;
        end
    end

endmodule

### sv/topg_emit.sv
module topg_emit #(
    parameter int ACC_BITS = topg_pkg::ACC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          tile_load,
    output logic                          tile_ready,
    input  logic [ACC_BITS-1:0]           tile_acc [topg_pkg::TILE_ROWS][topg_pkg::TILE_COLS],
    input  logic signed [topg_pkg::SCL_W-1:0] scale,
    input  logic signed [topg_pkg::OFS_W-1:0] offset,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [topg_pkg::OUT_W-1:0] m_d_col0,
    output logic signed [topg_pkg::OUT_W-1:0] m_d_col1,
    output logic signed [topg_pkg::OUT_W-1:0] m_d_col2,
    output logic signed [topg_pkg::OUT_W-1:0] m_d_col3,
    output logic [topg_pkg::ROW_W-1:0]    m_row_index,
    output logic                          m_final_row
);
    import topg_pkg::*;

    localparam int EXT_W = (ACC_BITS > CLAMP_BITS) ? ACC_BITS : CLAMP_BITS;
    localparam int PH_W = HI_BITS + SCL_W;
    localparam int PL_W = LO_BITS + 1 + SCL_W;
    localparam int SUM_W = PH_W + LO_BITS + 1;
    localparam int SHR_W = SUM_W - FRAC_SHIFT;
    localparam int T_W = SHR_W + 1;

    localparam logic signed [CLAMP_BITS-1:0] CL_MAX_N = {1'b0, {(CLAMP_BITS-1){1'b1}}};
    localparam logic signed [CLAMP_BITS-1:0] CL_MIN_N = {1'b1, {(CLAMP_BITS-1){1'b0}}};
    localparam logic signed [EXT_W-1:0] CL_MAX = EXT_W'(CL_MAX_N);
    localparam logic signed [EXT_W-1:0] CL_MIN = EXT_W'(CL_MIN_N);
    localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (FRAC_SHIFT - 1);
    localparam logic signed [T_W-1:0] T_MAX = T_W'(32'sh7FFF_FFFF);
    localparam logic signed [T_W-1:0] T_MIN = T_W'(32'sh8000_0000);

    logic                         busy_reg;
    logic [ROW_W-1:0]             row_reg;
    logic [ACC_BITS-1:0]          tile_reg [TILE_ROWS][TILE_COLS];
    logic                         en;
    logic                         issue;
    logic                         last_issue;

    logic                         v1_reg;
    logic [ROW_W-1:0]             row1_reg;
    logic signed [CLAMP_BITS-1:0] cl1_reg [TILE_COLS];
    logic signed [CLAMP_BITS-1:0] cl_next [TILE_COLS];

    logic                         v2_reg;
    logic [ROW_W-1:0]             row2_reg;
    logic signed [PH_W-1:0]       ph2_reg [TILE_COLS];
    logic signed [PL_W-1:0]       pl2_reg [TILE_COLS];

    logic                         v3_reg;
    logic [ROW_W-1:0]             row3_reg;
    logic [SUM_W-1:0]             sum3_reg [TILE_COLS];
    logic [SUM_W-1:0]             sum_next [TILE_COLS];

    logic                         m_valid_reg;
    logic [ROW_W-1:0]             m_row_reg;
    logic signed [OUT_W-1:0]      d_reg [TILE_COLS];
    logic signed [OUT_W-1:0]      d_next [TILE_COLS];

    assign en = !m_valid_reg || m_ready;
    assign issue = en && busy_reg;
    assign last_issue = issue && (row_reg == ROW_W'(TILE_ROWS - 1));
    assign tile_ready = !busy_reg || last_issue;

    always_comb begin
        logic signed [EXT_W-1:0] x;
        for (int c = 0; c < TILE_COLS; c++) begin
            x = EXT_W'($signed(tile_reg[row_reg][c]));
            if (x > CL_MAX) begin
                cl_next[c] = CL_MAX_N;
            end else if (x < CL_MIN) begin
                cl_next[c] = CL_MIN_N;
            end else begin
                cl_next[c] = x[CLAMP_BITS-1:0];
            end
        end
    end

    always_comb begin
        logic [SUM_W-1:0] ph_sh;
        logic [SUM_W-1:0] pl_ext;
        for (int c = 0; c < TILE_COLS; c++) begin
            ph_sh = {ph2_reg[c][PH_W-1], ph2_reg[c], {LO_BITS{1'b0}}};
            pl_ext = {{(SUM_W-PL_W){pl2_reg[c][PL_W-1]}}, pl2_reg[c]};
            sum_next[c] = ph_sh + pl_ext + RND;
        end
    end

    always_comb begin
        logic signed [T_W-1:0] t;
        for (int c = 0; c < TILE_COLS; c++) begin
            t = $signed({sum3_reg[c][SUM_W-1], sum3_reg[c][SUM_W-1:FRAC_SHIFT]})
                + $signed({{(T_W-OFS_W){offset[OFS_W-1]}}, offset});
            if (t > T_MAX) begin
                d_next[c] = T_MAX[OUT_W-1:0];
            end else if (t < T_MIN) begin
                d_next[c] = T_MIN[OUT_W-1:0];
            end else begin
                d_next[c] = t[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (tile_load) begin
                busy_reg <= 1'b1;
                row_reg <= '0;
            end else if (issue) begin
                if (last_issue) begin
                    busy_reg <= 1'b0;
                end
                row_reg <= row_reg + 1'b1;
            end
            if (en) begin
                v1_reg <= busy_reg;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                m_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tile_load) begin
            tile_reg <= tile_acc;
        end
        if (en) begin
            row1_reg <= row_reg;
            row2_reg <= row1_reg;
            row3_reg <= row2_reg;
            m_row_reg <= row3_reg;
            for (int c = 0; c < TILE_COLS; c++) begin
                cl1_reg[c] <= cl_next[c];
                ph2_reg[c] <= $signed(cl1_reg[c][CLAMP_BITS-1:LO_BITS]) * scale;
                pl2_reg[c] <= $signed({1'b0, cl1_reg[c][LO_BITS-1:0]}) * scale;
                sum3_reg[c] <= sum_next[c];
                d_reg[c] <= d_next[c];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_d_col0 = d_reg[0];
    assign m_d_col1 = d_reg[1];
    assign m_d_col2 = d_reg[2];
    assign m_d_col3 = d_reg[3];
    assign m_row_index = m_row_reg;
    assign m_final_row = m_row_reg == ROW_W'(TILE_ROWS - 1);

endmodule
